// ===== src/clnw_pkg.sv =====
// Package for the character-LCD nibble writer: operation codes, LCD command bytes,
// wait times and the queue entry and strobe types.
// No dependencies.
package clnw_pkg;

  typedef enum logic [2:0] {
    OP_INIT    = 3'd0,
    OP_WRITE   = 3'd1,
    OP_GOTO    = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_DISPLAY = 3'd4
  } op_e;

  localparam logic [3:0]  INIT_NIBBLE     = 4'h2;
  localparam logic [7:0]  CMD_FUNC_SET    = 8'h2C;
  localparam logic [7:0]  CMD_DISP_PLAIN  = 8'h0C;
  localparam logic [7:0]  CMD_CLEAR       = 8'h01;
  localparam logic [7:0]  CMD_ENTRY_MODE  = 8'h06;
  localparam logic [7:0]  CMD_SET_ADDR    = 8'h80;
  localparam logic [7:0]  CMD_DISP_ON     = 8'h0D;
  localparam logic [7:0]  CMD_DISP_OFF    = 8'h09;
  localparam logic [7:0]  CHAR_NEWLINE    = 8'd10;
  localparam logic [7:0]  COLUMN_MAX      = 8'd255;

  localparam logic [5:0]  WAIT_GOTO       = 6'd50;
  localparam logic [10:0] WAIT_NORMAL     = 11'd45;
  localparam logic [10:0] WAIT_CLEAR      = 11'd2000;

  localparam int unsigned INIT_STEPS      = 11;
  localparam int unsigned STEP_W          = $clog2(INIT_STEPS);
  localparam logic [STEP_W-1:0] INIT_LAST_STEP = STEP_W'(INIT_STEPS - 1);

  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic       is_init;
    logic       reg_select;
    logic [7:0] data;
    logic       is_goto;
    logic       is_clear;
  } cmd_t;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  bus_nibble;
    logic [5:0]  wait_before_us;
    logic [10:0] wait_after_us;
    logic        last_write;
  } strobe_t;

  // Command bytes that follow the lone nibble of the init sequence.
  function automatic logic [7:0] init_byte(logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = CMD_FUNC_SET;
      3'd1:    b = CMD_FUNC_SET;
      3'd2:    b = CMD_DISP_PLAIN;
      3'd3:    b = CMD_CLEAR;
      default: b = CMD_ENTRY_MODE;
    endcase
    return b;
  endfunction

  function automatic strobe_t init_strobe(logic [STEP_W-1:0] step);
    strobe_t         s;
    logic [STEP_W-1:0] idx;
    logic [7:0]      b;
    idx = step - 1'b1;
    b = init_byte(3'(idx[STEP_W-1:1]));
    s.reg_select = 1'b0;
    s.wait_before_us = '0;
    s.last_write = (step == INIT_LAST_STEP);
    if (step == '0) begin
      s.bus_nibble = INIT_NIBBLE;
      s.wait_after_us = '0;
    end else if (!idx[0]) begin
      s.bus_nibble = b[7:4];
      s.wait_after_us = '0;
    end else begin
      s.bus_nibble = b[3:0];
      s.wait_after_us = (b == CMD_CLEAR) ? WAIT_CLEAR : WAIT_NORMAL;
    end
    return s;
  endfunction

endpackage

// ===== src/clnw_op_if.sv =====
// Handshake channel that carries one LCD operation per transfer.
// Depends on nothing.
interface clnw_op_if ();
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] char_code;
  logic [5:0] target_column;
  logic       target_row;
  logic       display_enable;

  modport source (output valid, operation, char_code, target_column, target_row,
                  display_enable, input ready);
  modport sink (input valid, operation, char_code, target_column, target_row,
                display_enable, output ready);
endinterface

// ===== src/clnw_strobe_if.sv =====
// Handshake channel that carries one LCD bus strobe per transfer.
// Depends on nothing.
interface clnw_strobe_if ();
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic [3:0]  bus_nibble;
  logic [5:0]  wait_before_us;
  logic [10:0] wait_after_us;
  logic        last_write;

  modport source (output valid, reg_select, bus_nibble, wait_before_us, wait_after_us,
                  last_write, input ready);
  modport sink (input valid, reg_select, bus_nibble, wait_before_us, wait_after_us,
                last_write, output ready);
endinterface

// ===== src/clnw_front.sv =====
// Front part: accepts operations, keeps the cursor and turns each operation that needs
// one into a queue command. Depends on clnw_pkg and clnw_op_if.
module clnw_front import clnw_pkg::*; #(
  parameter int LINE2_COLUMNS = 8,
  parameter int ROW_STRIDE    = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  clnw_op_if.sink      op_i,
  input  logic         q_full_i,
  output logic         push_o,
  output cmd_t         cmd_o
);

  logic [7:0] col_q, col_d;
  logic       row_q, row_d;
  logic       accept;
  logic       make;
  logic [7:0] row_base;
  logic [7:0] goto_col;
  logic       goto_row;

  assign op_i.ready = !q_full_i;
  assign accept = op_i.valid && op_i.ready;

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    make     = 1'b0;
    cmd_o    = '0;
    goto_col = {2'b00, op_i.target_column};
    goto_row = op_i.target_row;
    unique case (op_e'(op_i.operation))
      OP_INIT: begin
        make = 1'b1;
        cmd_o.is_init = 1'b1;
        col_d = '0;
        row_d = 1'b0;
      end
      OP_WRITE: begin
        if (op_i.char_code == CHAR_NEWLINE) begin
          goto_col = '0;
          goto_row = 1'b1;
          if (!row_q) begin
            make = 1'b1;
            cmd_o.is_goto = 1'b1;
            col_d = '0;
            row_d = 1'b1;
          end
        end else if (!(row_q && col_q == 8'(LINE2_COLUMNS))) begin
          make = 1'b1;
          cmd_o.reg_select = 1'b1;
          cmd_o.data = op_i.char_code;
          if (col_q != COLUMN_MAX) begin
            col_d = col_q + 8'd1;
          end
        end
      end
      OP_GOTO: begin
        make = 1'b1;
        cmd_o.is_goto = 1'b1;
        col_d = goto_col;
        row_d = goto_row;
      end
      OP_CLEAR: begin
        make = 1'b1;
        cmd_o.is_clear = 1'b1;
        cmd_o.data = CMD_CLEAR;
        col_d = '0;
        row_d = 1'b0;
      end
      OP_DISPLAY: begin
        make = 1'b1;
        cmd_o.data = op_i.display_enable ? CMD_DISP_ON : CMD_DISP_OFF;
      end
      default: begin
        make = 1'b0;
      end
    endcase
    row_base = goto_row ? 8'(ROW_STRIDE) : 8'd0;
    if (cmd_o.is_goto) begin
      cmd_o.data = (row_base + goto_col) | CMD_SET_ADDR;
    end
  end

  assign push_o = accept && make;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= 1'b0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== src/clnw_queue.sv =====
// Short command queue between the front and back parts.
// Depends on clnw_pkg.
module clnw_queue import clnw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t head_o,
  input  logic pop_i
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("Command pushed into a full queue.");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("Command popped from an empty queue.");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("Queue fill count out of range.");
`endif

endmodule

// ===== src/clnw_back.sv =====
// Back part: serializes queued commands into nibble strobes into an output register.
// Depends on clnw_pkg and clnw_strobe_if.
module clnw_back import clnw_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  cmd_t          head_i,
  output logic          pop_o,
  clnw_strobe_if.source wr_o
);

  logic [STEP_W-1:0] step_q, step_d;
  strobe_t           out_q, cur;
  logic              out_valid_q;
  logic              advance;
  logic              load;

  always_comb begin
    if (head_i.is_init) begin
      cur = init_strobe(step_q);
    end else begin
      cur.reg_select = head_i.reg_select;
      if (!step_q[0]) begin
        cur.bus_nibble     = head_i.data[7:4];
        cur.wait_before_us = head_i.is_goto ? WAIT_GOTO : 6'd0;
        cur.wait_after_us  = '0;
        cur.last_write     = 1'b0;
      end else begin
        cur.bus_nibble     = head_i.data[3:0];
        cur.wait_before_us = '0;
        cur.wait_after_us  = head_i.is_clear ? WAIT_CLEAR : WAIT_NORMAL;
        cur.last_write     = 1'b1;
      end
    end
  end

  assign advance = !out_valid_q || wr_o.ready;
  assign load    = advance && q_valid_i;
  assign pop_o   = load && cur.last_write;

  always_comb begin
    step_d = step_q;
    if (pop_o) begin
      step_d = '0;
    end else if (load) begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (advance) begin
        out_valid_q <= q_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= cur;
    end
  end

  assign wr_o.valid          = out_valid_q;
  assign wr_o.reg_select     = out_q.reg_select;
  assign wr_o.bus_nibble     = out_q.bus_nibble;
  assign wr_o.wait_before_us = out_q.wait_before_us;
  assign wr_o.wait_after_us  = out_q.wait_after_us;
  assign wr_o.last_write     = out_q.last_write;

`ifndef NO_ASSERTIONS
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= INIT_LAST_STEP)
    else $error("Strobe step counter out of range.");
  a_byte_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_i && !head_i.is_init) |-> (step_q <= STEP_W'(1)))
    else $error("Byte command took more than two strobes.");
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_q && out_q.last_write && step_q == '0))
    else $error("Command retired without a final strobe.");
`endif

endmodule

// ===== src/char_lcd_nibble_writer_unit.sv =====
// Top level of the character-LCD nibble writer: front, command queue and back.
// Depends on clnw_pkg, clnw_op_if, clnw_strobe_if, clnw_front, clnw_queue, clnw_back.
// The block takes one LCD operation per transfer and emits 4-bit bus strobes, high
// nibble first, each tagged with register select, wait times and an end-of-operation
// mark. The front accepts one operation per cycle while the two-entry command queue
// has room and updates the cursor at once; the back serializer emits one strobe per
// cycle while the strobe sink is ready, so a character, goto, clear or display command
// yields two strobes, init yields 11, and a dropped character or ignored operation is
// taken at the front but yields no strobes. Sustained throughput is set by the back serializer.
module char_lcd_nibble_writer_unit import clnw_pkg::*; #(
  parameter int LINE2_COLUMNS = 8,
  parameter int ROW_STRIDE    = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  clnw_op_if.sink       op_i,
  clnw_strobe_if.source wr_o
);

  logic push, full, q_valid, pop;
  cmd_t cmd, head;

  clnw_front #(
    .LINE2_COLUMNS(LINE2_COLUMNS),
    .ROW_STRIDE   (ROW_STRIDE)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (op_i),
    .q_full_i(full),
    .push_o  (push),
    .cmd_o   (cmd)
  );

  clnw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .full_o (full),
    .valid_o(q_valid),
    .head_o (head),
    .pop_i  (pop)
  );

  clnw_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .head_i   (head),
    .pop_o    (pop),
    .wr_o     (wr_o)
  );

endmodule
